// ===== hw/rtl/hfsl_pkg.sv =====
`default_nettype none
package hfsl_pkg;

  localparam int HUE_W  = 16;
  localparam int LVL_W  = 8;
  localparam int MODE_W = 2;
  localparam int ACT_W  = 2;
  localparam int STEP_W = 8;
  localparam int FADE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // floor(x / 5) = (x * 52429) >> 18 for x < 2**18
  localparam int DIV5_W = 16;
  localparam logic [DIV5_W-1:0] DIV5_RECIP = 16'd52429;
  localparam int DIV5_SHIFT = 18;

  localparam logic [LVL_W-1:0]  FULL_LEVEL = 8'd255;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;
  localparam logic [FADE_W-1:0] FADE_RESET = 16'd10;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_COLOR  = 2'd1,
    ACT_BRIGHT = 2'd2,
    ACT_MODE   = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WHITE   = 2'd0,
    MODE_COLOR   = 2'd1,
    MODE_RAINBOW = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_FADE_STEP = 2'd1
  } reg_idx_t;

  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [MODE_W-1:0] mode_code_t;

  // Step now toward goal by step, stop at goal.
  function automatic lvl_t approach(input lvl_t now, input lvl_t goal,
                                    input logic [STEP_W-1:0] step);
    logic [LVL_W:0] up;
    lvl_t           res;
    up = {1'b0, now} + {1'b0, step};
    if (goal > now) begin
      res = (up > {1'b0, goal}) ? goal : up[LVL_W-1:0];
    end else if (step > now || (now - step) < goal) begin
      res = goal;
    end else begin
      res = now - step;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hfsl_in_if.sv =====
`default_nettype none
interface hfsl_in_if;
  logic                       valid;
  logic                       ready;
  logic [hfsl_pkg::ACT_W-1:0]  action;
  logic [hfsl_pkg::HUE_W-1:0]  hue;
  logic [hfsl_pkg::LVL_W-1:0]  sat;
  logic [hfsl_pkg::LVL_W-1:0]  val;
  logic [hfsl_pkg::LVL_W-1:0]  level;
  logic [hfsl_pkg::MODE_W-1:0] mode;

  modport source (output valid, action, hue, sat, val, level, mode, input ready);
  modport sink   (input valid, action, hue, sat, val, level, mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hfsl_out_if.sv =====
`default_nettype none
interface hfsl_out_if;
  logic                       valid;
  logic                       ready;
  logic [hfsl_pkg::HUE_W-1:0]  hue_now;
  logic [hfsl_pkg::LVL_W-1:0]  sat_now;
  logic [hfsl_pkg::LVL_W-1:0]  val_now;
  logic [hfsl_pkg::LVL_W-1:0]  bright_now;
  logic [hfsl_pkg::MODE_W-1:0] mode_now;
  logic                       refresh;

  modport source (output valid, hue_now, sat_now, val_now, bright_now, mode_now, refresh,
                  input ready);
  modport sink   (input valid, hue_now, sat_now, val_now, bright_now, mode_now, refresh,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hsv_fade_slew_limiter.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    action, hue, sat, val, level, mode
// out_ch   out  valid/ready    hue_now, sat_now, val_now, bright_now, mode_now, refresh
// cfg      in   cfg_we only    cfg_addr, cfg_wdata
//
// Input register, then one pass of update logic; hue step: subtract, divide by 20, add.
// One item per cycle while no tick waits on a held result; the hue step bounds the pass.
// Synchronous active-low reset; state, goals and mode clear, step_size 1, fade_step 10.
// A tick waits in the input register while a result is held; commands pass a held result.
`default_nettype none
module hsv_fade_slew_limiter (
  input  wire                              clk,
  input  wire                              rst_n,
  hfsl_in_if.sink                          in_ch,
  hfsl_out_if.source                       out_ch,
  input  wire                              cfg_we,
  input  wire [hfsl_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire [hfsl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hfsl_pkg::*;

  logic [STEP_W-1:0] step_size_r;
  logic [FADE_W-1:0] fade_step_r;

  logic       in_valid_r;
  action_t    in_act_r;
  hue_t       in_hue_r;
  lvl_t       in_sat_r, in_val_r, in_level_r;
  mode_code_t in_mode_r;

  hue_t       cur_hue_r, cur_hue_nxt, goal_hue_r, goal_hue_nxt;
  lvl_t       cur_sat_r, cur_sat_nxt, cur_val_r, cur_val_nxt;
  lvl_t       cur_bright_r, cur_bright_nxt;
  lvl_t       goal_sat_r, goal_sat_nxt, goal_val_r, goal_val_nxt;
  lvl_t       goal_bright_r, goal_bright_nxt;
  mode_t      active_mode_r, active_mode_nxt;

  mode_t      shown_mode_r;
  hue_t       shown_hue_r;
  lvl_t       shown_sat_r, shown_val_r, shown_bright_r;

  logic       out_valid_r;
  hue_t       out_hue_r;
  lvl_t       out_sat_r, out_val_r, out_bright_r;
  mode_code_t out_mode_r;
  logic       out_refresh_r;

  logic       is_tick, proc_fire, tick_fire, hv_change, refresh_nxt;
  hue_t       hue_step;

  assign is_tick   = (in_act_r == ACT_TICK);
  assign proc_fire = in_valid_r && (!is_tick || !out_valid_r || out_ch.ready);
  assign tick_fire = proc_fire && is_tick;

  assign in_ch.ready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_RESET;
      fade_step_r <= FADE_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_STEP_SIZE) begin
        step_size_r <= cfg_wdata[STEP_W-1:0];
      end else if (cfg_addr == REG_FADE_STEP) begin
        fade_step_r <= cfg_wdata[FADE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_act_r   <= action_t'(in_ch.action);
      in_hue_r   <= in_ch.hue;
      in_sat_r   <= in_ch.sat;
      in_val_r   <= in_ch.val;
      in_level_r <= in_ch.level;
      in_mode_r  <= in_ch.mode;
    end
  end

  hfsl_hue_step u_hue_step (
    .cur_hue  (cur_hue_r),
    .goal_hue (goal_hue_r),
    .hue_nxt  (hue_step)
  );

  assign hv_change = (cur_hue_r != goal_hue_r) || (cur_sat_r != goal_sat_r) ||
                     (cur_val_r != goal_val_r);

  always_comb begin
    cur_hue_nxt     = cur_hue_r;
    cur_sat_nxt     = cur_sat_r;
    cur_val_nxt     = cur_val_r;
    cur_bright_nxt  = cur_bright_r;
    goal_hue_nxt    = goal_hue_r;
    goal_sat_nxt    = goal_sat_r;
    goal_val_nxt    = goal_val_r;
    goal_bright_nxt = goal_bright_r;
    active_mode_nxt = active_mode_r;
    unique case (in_act_r)
      ACT_TICK: begin
        if (hv_change) begin
          cur_hue_nxt = hue_step;
          cur_sat_nxt = approach(cur_sat_r, goal_sat_r, step_size_r);
          cur_val_nxt = approach(cur_val_r, goal_val_r, step_size_r);
        end
        cur_bright_nxt = approach(cur_bright_r, goal_bright_r, step_size_r);
        if (active_mode_r == MODE_RAINBOW) begin
          goal_hue_nxt = goal_hue_r + fade_step_r;
          goal_sat_nxt = FULL_LEVEL;
          goal_val_nxt = FULL_LEVEL;
        end
      end
      ACT_COLOR: begin
        goal_hue_nxt    = in_hue_r;
        goal_sat_nxt    = in_sat_r;
        goal_val_nxt    = in_val_r;
        active_mode_nxt = MODE_COLOR;
      end
      ACT_BRIGHT: begin
        goal_bright_nxt = in_level_r;
      end
      ACT_MODE: begin
        if (in_mode_r <= mode_code_t'(MODE_RAINBOW)) begin
          active_mode_nxt = mode_t'(in_mode_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign refresh_nxt = (active_mode_r != shown_mode_r) || (cur_bright_nxt != shown_bright_r) ||
                       (cur_hue_nxt != shown_hue_r) || (cur_sat_nxt != shown_sat_r) ||
                       (cur_val_nxt != shown_val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_hue_r     <= '0;
      cur_sat_r     <= '0;
      cur_val_r     <= '0;
      cur_bright_r  <= '0;
      goal_hue_r    <= '0;
      goal_sat_r    <= '0;
      goal_val_r    <= '0;
      goal_bright_r <= '0;
      active_mode_r <= MODE_WHITE;
    end else if (proc_fire) begin
      cur_hue_r     <= cur_hue_nxt;
      cur_sat_r     <= cur_sat_nxt;
      cur_val_r     <= cur_val_nxt;
      cur_bright_r  <= cur_bright_nxt;
      goal_hue_r    <= goal_hue_nxt;
      goal_sat_r    <= goal_sat_nxt;
      goal_val_r    <= goal_val_nxt;
      goal_bright_r <= goal_bright_nxt;
      active_mode_r <= active_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_mode_r   <= MODE_WHITE;
      shown_hue_r    <= '0;
      shown_sat_r    <= '0;
      shown_val_r    <= '0;
      shown_bright_r <= '0;
    end else if (tick_fire && refresh_nxt) begin
      shown_mode_r   <= active_mode_r;
      shown_hue_r    <= cur_hue_nxt;
      shown_sat_r    <= cur_sat_nxt;
      shown_val_r    <= cur_val_nxt;
      shown_bright_r <= cur_bright_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_hue_r     <= cur_hue_nxt;
      out_sat_r     <= cur_sat_nxt;
      out_val_r     <= cur_val_nxt;
      out_bright_r  <= cur_bright_nxt;
      out_mode_r    <= mode_code_t'(active_mode_r);
      out_refresh_r <= refresh_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hue_now    = out_hue_r;
  assign out_ch.sat_now    = out_sat_r;
  assign out_ch.val_now    = out_val_r;
  assign out_ch.bright_now = out_bright_r;
  assign out_ch.mode_now   = out_mode_r;
  assign out_ch.refresh    = out_refresh_r;

  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> out_valid_r)
    else $error("tick did not load a result");

  a_no_fire_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !proc_fire |=> $stable(cur_hue_r) && $stable(cur_bright_r) && $stable(goal_hue_r))
    else $error("state moved without an item");

  a_bright_no_overshoot_up: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && (cur_bright_r <= goal_bright_r) |=>
      (cur_bright_r <= $past(goal_bright_r)) && (cur_bright_r >= $past(cur_bright_r)))
    else $error("brightness passed its goal going up");

  a_bright_no_overshoot_down: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && (cur_bright_r >= goal_bright_r) |=>
      (cur_bright_r >= $past(goal_bright_r)) && (cur_bright_r <= $past(cur_bright_r)))
    else $error("brightness passed its goal going down");

  a_stall_blocks_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !tick_fire)
    else $error("tick overwrote a held result");

endmodule
`default_nettype wire

// ===== hw/rtl/hfsl_hue_step.sv =====
`default_nettype none
module hfsl_hue_step (
  input  wire hfsl_pkg::hue_t cur_hue,
  input  wire hfsl_pkg::hue_t goal_hue,
  output hfsl_pkg::hue_t      hue_nxt
);
  import hfsl_pkg::*;

  localparam int MAG_W  = HUE_W + 1;
  localparam int QTR_W  = MAG_W - 2;
  localparam int PROD_W = QTR_W + DIV5_W;
  localparam int SP_W   = PROD_W - DIV5_SHIFT;

  hue_t              delta;
  logic              down;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SP_W-1:0]   quot;
  logic [SP_W-1:0]   sp;

  // shorter way round: half circle goes downward
  assign delta = goal_hue - cur_hue;
  assign down  = delta[HUE_W-1];
  assign mag   = down ? ((MAG_W'(1) << HUE_W) - {1'b0, delta}) : {1'b0, delta};

  // mag / 20 as (mag / 4) / 5
  assign prod = PROD_W'(mag[MAG_W-1:2]) * PROD_W'(DIV5_RECIP);
  assign quot = prod[PROD_W-1:DIV5_SHIFT];
  assign sp   = (quot == '0) ? SP_W'(1) : quot;

  always_comb begin
    if (mag <= MAG_W'(sp)) begin
      hue_nxt = goal_hue;
    end else if (down) begin
      hue_nxt = cur_hue - HUE_W'(sp);
    end else begin
      hue_nxt = cur_hue + HUE_W'(sp);
    end
  end

endmodule
`default_nettype wire
